/* sv/pcs_pkg.sv */
// pcs_pkg: shared types and constants for the priority counting semaphore
// holds transaction structs, controller/datapath link structs and result codes
// no dependencies
package pcs_pkg;

    localparam int PID_BITS     = 8;
    localparam int PRIO_BITS    = 4;
    localparam int COUNT_BITS   = 16;
    localparam int WAITING_BITS = 4;

    localparam logic [PRIO_BITS-1:0] PRIO_IDLE = '1;

    localparam logic ACT_WAIT   = 1'b0;
    localparam logic ACT_SIGNAL = 1'b1;

    localparam logic [1:0] SW_CONTINUE = 2'd0;
    localparam logic [1:0] SW_BLOCK    = 2'd1;
    localparam logic [1:0] SW_YIELD    = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LIST_FULL = 2'd1;
    localparam logic [1:0] ERR_SATURATED = 2'd2;

    typedef struct packed {
        logic                 action;
        logic [PID_BITS-1:0]  caller_pid;
        logic [PRIO_BITS-1:0] caller_priority;
    } pcs_req_t;

    typedef struct packed {
        logic [1:0]              switch_request;
        logic                    woken_valid;
        logic [PID_BITS-1:0]     woken_pid;
        logic [1:0]              error_flag;
        logic [COUNT_BITS-1:0]   count_now;
        logic [WAITING_BITS-1:0] waiting_now;
    } pcs_rsp_t;

    typedef struct packed {
        logic [PID_BITS-1:0]  pid;
        logic [PRIO_BITS-1:0] prio;
    } pcs_entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } pcs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } pcs_sts_t;

endpackage

/* sv/priority_counting_semaphore_core.sv */
// priority_counting_semaphore_core: counting semaphore with a priority wait list
// top level joining the pcs_ctrl sequencer and the pcs_datapath
// depends on pcs_pkg, pcs_ctrl, pcs_datapath
//
// usage:
//   s_valid/s_ready/s_data carry one request transaction: a wait or a signal
//   with the caller's pid and priority. m_valid/m_ready/m_data return one
//   result transaction per request, in order.
//   cfg_valid/cfg_ready/cfg_init_count load the count and empty the wait list;
//   cfg_ready is always high. write it only while no request is in flight.
//   a request is captured into the request register at acceptance, and its
//   result is loaded into the output register once that register is free;
//   m_valid rises with it. a new request is taken only after the previous one
//   is committed, since the sequencer captures and then commits each in turn.
//   a result waiting on m_ready does not block the next request from being
//   taken; that request is held until the output register is free.
//   reset: count is 1, wait list empty, no result pending.
//   the wait list holds WAIT_DEPTH entries, sorted by priority, equal priority
//   in arrival order.
module priority_counting_semaphore_core #(
    parameter int WAIT_DEPTH = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pcs_pkg::COUNT_BITS-1:0] cfg_init_count,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pcs_pkg::pcs_req_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pcs_pkg::pcs_rsp_t              m_data
);
    import pcs_pkg::*;

    pcs_cmd_t cmd;
    pcs_sts_t sts;

    assign cfg_ready = 1'b1;

    pcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcs_datapath #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_init_count (cfg_init_count),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

/* sv/pcs_ctrl.sv */
// pcs_ctrl: request sequencer for the priority counting semaphore
// captures one transaction, then commits it once the result register is free
// depends on pcs_pkg
module pcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcs_pkg::pcs_sts_t sts,
    output pcs_pkg::pcs_cmd_t cmd
);
    import pcs_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold the request until the previous result has left
                cmd.commit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/pcs_datapath.sv */
// pcs_datapath: count register, sorted wait list row and result register
// the wait list is a row of compare-and-shift cells kept in service order
// depends on pcs_pkg
module pcs_datapath #(
    parameter int WAIT_DEPTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [pcs_pkg::COUNT_BITS-1:0]      cfg_init_count,
    input  pcs_pkg::pcs_req_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pcs_pkg::pcs_rsp_t                   m_data,
    input  pcs_pkg::pcs_cmd_t                   cmd,
    output pcs_pkg::pcs_sts_t                   sts
);
    import pcs_pkg::*;

    localparam int TOT_W = $clog2(WAIT_DEPTH + 1);

    pcs_req_t              req_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [TOT_W-1:0]      total_reg;
    logic [TOT_W-1:0]      total_next;
    pcs_entry_t            cells_reg  [WAIT_DEPTH];
    pcs_entry_t            cells_next [WAIT_DEPTH];
    logic [WAIT_DEPTH-1:0] stay;
    pcs_rsp_t              rsp_reg;
    pcs_rsp_t              rsp_next;
    logic                  valid_reg;
    logic [31:0]           total_wide;

    logic is_wait;
    logic count_zero;
    logic count_max;
    logic list_full;
    logic list_empty;
    logic do_insert;
    logic do_remove;
    pcs_entry_t new_entry;
    pcs_entry_t idle_entry;

    assign is_wait    = (req_reg.action == ACT_WAIT);
    assign count_zero = (count_reg == '0);
    assign count_max  = (count_reg == '1);
    assign list_full  = (total_reg == TOT_W'(WAIT_DEPTH));
    assign list_empty = (total_reg == '0);
    assign do_insert  = is_wait && count_zero && !list_full;
    assign do_remove  = !is_wait && !list_empty;

    assign new_entry.pid   = req_reg.caller_pid;
    assign new_entry.prio  = req_reg.caller_priority;
    assign idle_entry.pid  = '0;
    assign idle_entry.prio = PRIO_IDLE;

    // a valid cell whose priority is not worse than the newcomer keeps its place
    always_comb begin
        for (int i = 0; i < WAIT_DEPTH; i++) begin
            stay[i] = (TOT_W'(i) < total_reg) &&
                      (cells_reg[i].prio <= req_reg.caller_priority);
        end
    end

    always_comb begin
        for (int i = 0; i < WAIT_DEPTH; i++) begin
            cells_next[i] = cells_reg[i];
            if (do_insert) begin
                if (!stay[i]) begin
                    if (i == 0) begin
                        cells_next[i] = new_entry;
                    end else if (stay[i-1]) begin
                        cells_next[i] = new_entry;
                    end else begin
                        cells_next[i] = cells_reg[i-1];
                    end
                end
            end else if (do_remove) begin
                if (i < WAIT_DEPTH - 1) begin
                    cells_next[i] = cells_reg[i+1];
                end else begin
                    cells_next[i] = idle_entry;
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        rsp_next.switch_request = SW_CONTINUE;
        rsp_next.woken_valid    = 1'b0;
        rsp_next.woken_pid      = '0;
        rsp_next.error_flag     = ERR_NONE;
        if (is_wait) begin
            if (!count_zero) begin
                count_next = count_reg - COUNT_BITS'(1);
            end else if (list_full) begin
                rsp_next.error_flag = ERR_LIST_FULL;
            end else begin
                total_next = total_reg + TOT_W'(1);
                rsp_next.switch_request = SW_BLOCK;
            end
        end else begin
            rsp_next.switch_request = SW_YIELD;
            if (list_empty) begin
                if (count_max) begin
                    rsp_next.error_flag = ERR_SATURATED;
                end else begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end else begin
                total_next           = total_reg - TOT_W'(1);
                rsp_next.woken_valid = 1'b1;
                rsp_next.woken_pid   = cells_reg[0].pid;
            end
        end
        total_wide           = 32'(total_next);
        rsp_next.count_now   = count_next;
        rsp_next.waiting_now = total_wide[WAITING_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < WAIT_DEPTH; i++) begin
                cells_reg[i] <= cells_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_BITS'(1);
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                count_reg <= cfg_init_count;
                total_reg <= '0;
            end else if (cmd.commit) begin
                count_reg <= count_next;
                total_reg <= total_next;
            end
            if (cmd.commit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_data       = rsp_reg;
    assign sts.out_free = !valid_reg || m_ready;

endmodule
